// ===== rtl/pqd_pkg.sv =====
// Types, constants and per-step functions for the packed quaternion decoder.
// Used by packed_quaternion_decoder; no dependencies.
`default_nettype none

package pqd_pkg;

    localparam int unsigned AXIS_STEPS = 32;
    localparam int unsigned ROOT_STEPS = 31;

    localparam logic [61:0] ONE_Q60       = 62'h1000_0000_0000_0000;
    localparam logic [61:0] NEAR_ZERO_Q60 = 62'd11529215047;
    localparam logic [32:0] ONE_Q30       = 33'h0_4000_0000;
    localparam logic [9:0]  MAX_MAG_XY    = 10'h3FF;
    localparam logic [9:0]  MAX_MAG_Z     = 10'h1FF;
    localparam logic [7:0]  FMT_ALL_ONES  = 8'hFF;

    typedef struct packed {
        logic        ok;
        logic [16:0] den;
        logic [16:0] rem;
        logic [31:0] dq;
    } adiv_t;

    typedef struct packed {
        logic [30:0] mag;
        logic        pos;
    } comp_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] root;
        logic [61:0] opnd;
    } root_t;

    function automatic adiv_t axis_init(input logic [10:0] fld, input logic is_z,
                                        input logic [7:0] fmt);
        logic [3:0]  k;
        logic        run;
        logic [7:0]  cnt;
        logic [6:0]  idx;
        logic [9:0]  m;
        logic [9:0]  mag;
        logic        neg;
        logic [16:0] prod;
        logic [16:0] num;
        logic [16:0] den;
        logic [48:0] dvd;
        adiv_t       r;
        k   = '0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            run = run & fmt[i];
            k   = k + {3'b000, run};
        end
        cnt  = 8'd1 << (3'd7 - k[2:0]);
        idx  = fmt[6:0] & (cnt[6:0] - 7'd1);
        m    = is_z ? MAX_MAG_Z : MAX_MAG_XY;
        mag  = is_z ? {1'b0, fld[8:0]} : fld[9:0];
        neg  = is_z ? fld[9] : fld[10];
        prod = ({10'd0, idx} + 17'd1) * {7'd0, m};
        num  = neg ? prod - {7'd0, mag} : prod + {7'd0, mag};
        den  = ({9'd0, cnt} + 17'd1) * {7'd0, m};
        r.ok = fmt[7] && (fmt != FMT_ALL_ONES);
        if (!r.ok)
        begin
            num = '0;
            den = 17'd1;
        end
        dvd   = {1'b0, num, 31'd0} + {33'd0, den[16:1]};
        r.den = den;
        r.rem = dvd[48:32];
        r.dq  = dvd[31:0];
        return r;
    endfunction

    function automatic adiv_t axis_step(input adiv_t a);
        logic [17:0] t;
        adiv_t       r;
        r = a;
        t = {a.rem, a.dq[31]};
        if (t >= {1'b0, a.den})
        begin
            r.rem = 17'(t - {1'b0, a.den});
            r.dq  = {a.dq[30:0], 1'b1};
        end
        else
        begin
            r.rem = t[16:0];
            r.dq  = {a.dq[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic root_t root_init(input logic [61:0] v);
        root_t r;
        r.rem  = '0;
        r.root = '0;
        r.opnd = v;
        return r;
    endfunction

    function automatic root_t root_step(input root_t a);
        logic [34:0] t;
        logic [34:0] trial;
        root_t       r;
        t      = {a.rem, a.opnd[61:60]};
        trial  = {2'b00, a.root, 2'b01};
        r.opnd = {a.opnd[59:0], 2'b00};
        if (t >= trial)
        begin
            r.rem  = 33'(t - trial);
            r.root = {a.root[29:0], 1'b1};
        end
        else
        begin
            r.rem  = t[32:0];
            r.root = {a.root[29:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/packed_quaternion_decoder.sv =====
// Throughput: one word per cycle; the whole pipeline holds while out_valid waits on out_ready.
// Stages: 32 axis divide steps, two 31-step square roots, FRACTION_BITS+1 output divide steps.
// Reset: rst_n clears all stage valid bits asynchronously; data registers are not reset.
// Top level of the packed quaternion decoder; depends on pqd_pkg.
`default_nettype none

module packed_quaternion_decoder #(
    parameter int unsigned FRACTION_BITS = 14
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        packed_word,
    input  wire logic [7:0]         format_x,
    input  wire logic [7:0]         format_y,
    input  wire logic [7:0]         format_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z,
    output logic signed [15:0]      quat_w
);

    localparam int unsigned AS     = pqd_pkg::AXIS_STEPS;
    localparam int unsigned RS     = pqd_pkg::ROOT_STEPS;
    localparam int unsigned QW     = FRACTION_BITS + 1;
    localparam int unsigned DW     = FRACTION_BITS + 32;
    localparam int unsigned ST_A   = AS + 1;
    localparam int unsigned ST_W2  = AS + RS + 4;
    localparam int unsigned ST_OUT = AS + 2 * RS + FRACTION_BITS + 8;
    localparam logic [QW-1:0] ONE_Q = {1'b1, {FRACTION_BITS{1'b0}}};

    logic                advance;
    logic [ST_OUT:0]     vld_reg;

    pqd_pkg::adiv_t      ax_reg   [0:AS][3];
    pqd_pkg::comp_t      cmpa_next[3];
    pqd_pkg::comp_t      cmpa_reg [3];
    logic [32:0]         a33      [3];
    logic [32:0]         na33     [3];
    pqd_pkg::comp_t      cmpq_reg [3];
    logic [61:0]         sq_reg   [3];
    logic [61:0]         s_sum;
    logic [61:0]         v_sum;
    pqd_pkg::comp_t      cmp1_reg [0:RS][3];
    logic [61:0]         s1_reg   [0:RS];
    pqd_pkg::root_t      r1_reg   [0:RS];
    pqd_pkg::comp_t      cmpw_reg [3];
    logic [61:0]         sw_reg;
    logic [30:0]         w_reg;
    logic [61:0]         ww_reg;
    logic [61:0]         n2_sum;
    pqd_pkg::comp_t      cmp2_reg [0:RS][3];
    logic [30:0]         w2_reg   [0:RS];
    logic                z2_reg   [0:RS];
    pqd_pkg::root_t      r2_reg   [0:RS];
    logic [30:0]         lane_mag [4];
    logic                lane_neg [4];
    logic [DW-1:0]       lane_dvd [4];
    logic [30:0]         orem_reg [0:QW][4];
    logic [QW-1:0]       odq_reg  [0:QW][4];
    logic                oneg_reg [0:QW][4];
    logic [30:0]         on_reg   [0:QW];
    logic                oz_reg   [0:QW];
    logic [QW-1:0]       qclip    [4];
    logic [QW+15:0]      qext     [4];
    logic [QW+15:0]      qsgn     [4];
    logic [QW+15:0]      one_ext;
    logic [15:0]         out_next [4];
    logic [15:0]         out_reg  [4];

    assign advance   = !vld_reg[ST_OUT] || out_ready;
    assign in_ready  = advance;
    assign out_valid = vld_reg[ST_OUT];
    assign quat_x    = out_reg[0];
    assign quat_y    = out_reg[1];
    assign quat_z    = out_reg[2];
    assign quat_w    = out_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[ST_OUT-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax_reg[0][0] <= pqd_pkg::axis_init(packed_word[31:21], 1'b0, format_x);
            ax_reg[0][1] <= pqd_pkg::axis_init(packed_word[20:10], 1'b0, format_y);
            ax_reg[0][2] <= pqd_pkg::axis_init({1'b0, packed_word[9:0]}, 1'b1, format_z);
        end
    end

    for (genvar j = 1; j <= AS; j++)
    begin : g_axis
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    ax_reg[j][l] <= pqd_pkg::axis_step(ax_reg[j-1][l]);
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            a33[l]  = {1'b0, ax_reg[AS][l].dq} - pqd_pkg::ONE_Q30;
            na33[l] = 33'd0 - a33[l];
            if (ax_reg[AS][l].ok)
            begin
                cmpa_next[l].mag = a33[l][32] ? na33[l][30:0] : a33[l][30:0];
                cmpa_next[l].pos = !a33[l][32] && (a33[l] != 33'd0);
            end
            else
            begin
                cmpa_next[l].mag = '0;
                cmpa_next[l].pos = 1'b0;
            end
        end
        s_sum = sq_reg[0] + sq_reg[1] + sq_reg[2];
        v_sum = (s_sum < pqd_pkg::ONE_Q60) ? pqd_pkg::ONE_Q60 - s_sum : 62'd0;
        n2_sum = sw_reg + ww_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < 3; l++)
            begin
                cmpa_reg[l]    <= cmpa_next[l];
                cmpq_reg[l]    <= cmpa_reg[l];
                sq_reg[l]      <= {31'd0, cmpa_reg[l].mag} * {31'd0, cmpa_reg[l].mag};
                cmp1_reg[0][l] <= cmpq_reg[l];
                cmpw_reg[l]    <= cmp1_reg[RS][l];
                cmp2_reg[0][l] <= cmpw_reg[l];
            end
            s1_reg[0] <= s_sum;
            r1_reg[0] <= pqd_pkg::root_init(v_sum);
            sw_reg    <= s1_reg[RS];
            w_reg     <= r1_reg[RS].root;
            ww_reg    <= {31'd0, r1_reg[RS].root} * {31'd0, r1_reg[RS].root};
            w2_reg[0] <= w_reg;
            z2_reg[0] <= n2_sum < pqd_pkg::NEAR_ZERO_Q60;
            r2_reg[0] <= pqd_pkg::root_init(n2_sum);
        end
    end

    for (genvar j = 1; j <= RS; j++)
    begin : g_root
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                r1_reg[j] <= pqd_pkg::root_step(r1_reg[j-1]);
                s1_reg[j] <= s1_reg[j-1];
                r2_reg[j] <= pqd_pkg::root_step(r2_reg[j-1]);
                w2_reg[j] <= w2_reg[j-1];
                z2_reg[j] <= z2_reg[j-1];
                for (int l = 0; l < 3; l++)
                begin
                    cmp1_reg[j][l] <= cmp1_reg[j-1][l];
                    cmp2_reg[j][l] <= cmp2_reg[j-1][l];
                end
            end
        end
    end

    always_comb
    begin
        lane_mag[0] = cmp2_reg[RS][0].mag;
        lane_neg[0] = cmp2_reg[RS][0].pos;
        lane_mag[1] = cmp2_reg[RS][2].mag;
        lane_neg[1] = cmp2_reg[RS][2].pos;
        lane_mag[2] = cmp2_reg[RS][1].mag;
        lane_neg[2] = cmp2_reg[RS][1].pos;
        lane_mag[3] = w2_reg[RS];
        lane_neg[3] = 1'b0;
        for (int l = 0; l < 4; l++)
        begin
            lane_dvd[l] = {1'b0, lane_mag[l], {FRACTION_BITS{1'b0}}}
                        + {{(DW-30){1'b0}}, r2_reg[RS].root[30:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            on_reg[0] <= r2_reg[RS].root;
            oz_reg[0] <= z2_reg[RS];
            for (int l = 0; l < 4; l++)
            begin
                orem_reg[0][l] <= lane_dvd[l][DW-1:QW];
                odq_reg[0][l]  <= lane_dvd[l][QW-1:0];
                oneg_reg[0][l] <= lane_neg[l];
            end
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_odiv
        logic [31:0] t   [4];
        logic        hit [4];

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                t[l]   = {orem_reg[j-1][l], odq_reg[j-1][l][QW-1]};
                hit[l] = t[l] >= {1'b0, on_reg[j-1]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                on_reg[j] <= on_reg[j-1];
                oz_reg[j] <= oz_reg[j-1];
                for (int l = 0; l < 4; l++)
                begin
                    orem_reg[j][l] <= hit[l] ? 31'(t[l] - {1'b0, on_reg[j-1]})
                                             : t[l][30:0];
                    odq_reg[j][l]  <= {odq_reg[j-1][l][QW-2:0], hit[l]};
                    oneg_reg[j][l] <= oneg_reg[j-1][l];
                end
            end
        end
    end

    always_comb
    begin
        one_ext = {16'd0, ONE_Q};
        for (int l = 0; l < 4; l++)
        begin
            qclip[l] = (odq_reg[QW][l] > ONE_Q) ? ONE_Q : odq_reg[QW][l];
            qext[l]  = {16'd0, qclip[l]};
            qsgn[l]  = oneg_reg[QW][l] ? ({(QW+16){1'b0}} - qext[l]) : qext[l];
            out_next[l] = oz_reg[QW] ? 16'd0 : qsgn[l][15:0];
        end
        if (oz_reg[QW])
        begin
            out_next[3] = one_ext[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < 4; l++)
            begin
                out_reg[l] <= out_next[l];
            end
        end
    end

`ifndef SYNTHESIS
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_A] |-> (cmpa_reg[0].mag <= 31'h4000_0000)
                          && (cmpa_reg[1].mag <= 31'h4000_0000)
                          && (cmpa_reg[2].mag <= 31'h4000_0000))
        else $error("decoded axis magnitude above one");

    a_unit_norm: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_W2] && (sw_reg < pqd_pkg::ONE_Q60) |-> (sw_reg + ww_reg <= pqd_pkg::ONE_Q60))
        else $error("reconstructed w overshoots unit norm");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_OUT-1] && !oz_reg[QW] |-> (odq_reg[QW][0] <= ONE_Q)
                                            && (odq_reg[QW][1] <= ONE_Q)
                                            && (odq_reg[QW][2] <= ONE_Q)
                                            && (odq_reg[QW][3] <= ONE_Q))
        else $error("output quotient above one");

    a_w_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (FRACTION_BITS < 15) |-> !quat_w[15])
        else $error("negative w component");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for packed_quaternion_decoder.
// Predicts each decoded quaternion in fixed point and checks results in order.
// Depends on the packed_quaternion_decoder RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC = 14;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } quat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] packed_word;
    logic [7:0]  format_x;
    logic [7:0]  format_y;
    logic [7:0]  format_z;
    logic        out_valid;
    logic        out_ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    quat_t expected_quats[$];
    int    mismatch_count;
    int    word_count;
    int    result_count;
    int    stall_left;
    bit    idle_enable;

    packed_quaternion_decoder #(.FRACTION_BITS(FRAC)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .packed_word(packed_word), .format_x(format_x),
        .format_y(format_y), .format_z(format_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint axis_q30(input logic [10:0] fld, input bit is_z,
                                        input logic [7:0] fmt);
        int          k;
        logic [63:0] cnt;
        logic [63:0] idx;
        logic [63:0] m;
        logic [63:0] mag;
        bit          neg;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        k = 0;
        while (k < 8 && fmt[7 - k])
            k++;
        if (k < 1 || k > 7)
            return 0;
        cnt = 64'd1 << (7 - k);
        idx = fmt & (cnt - 1);
        m   = is_z ? 64'd511 : 64'd1023;
        mag = is_z ? fld[8:0] : fld[9:0];
        neg = is_z ? fld[9] : fld[10];
        num = (idx + 1) * m;
        num = neg ? num - mag : num + mag;
        den = (cnt + 1) * m;
        q   = ((num << 31) + den / 2) / den;
        return longint'(q) - (longint'(1) << 30);
    endfunction

    function automatic logic [15:0] scale_component(input longint c, input logic [63:0] n);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (c < 0) ? -c : c;
        q   = ((mag << FRAC) + n / 2) / n;
        if (q > (64'd1 << FRAC))
            q = 64'd1 << FRAC;
        if (c < 0)
            q = -q;
        return q[15:0];
    endfunction

    function automatic quat_t decode_quat(input logic [31:0] pw, input logic [7:0] fx,
                                          input logic [7:0] fy, input logic [7:0] fz);
        longint      x;
        longint      y;
        longint      z;
        logic [63:0] s;
        logic [63:0] w;
        logic [63:0] n2;
        logic [63:0] n;
        quat_t       r;
        x = axis_q30(pw[31:21], 1'b0, fx);
        y = axis_q30(pw[20:10], 1'b0, fy);
        z = axis_q30({1'b0, pw[9:0]}, 1'b1, fz);
        s = x * x + y * y + z * z;
        w = 0;
        if (s < (64'd1 << 60))
            w = int_sqrt((64'd1 << 60) - s);
        n2 = s + w * w;
        if (n2 < 64'd11529215047)
        begin
            r.qx = 0;
            r.qy = 0;
            r.qz = 0;
            r.qw = 16'(1 << FRAC);
            return r;
        end
        n    = int_sqrt(n2);
        r.qx = scale_component(-x, n);
        r.qy = scale_component(-z, n);
        r.qz = scale_component(-y, n);
        r.qw = scale_component(longint'(w), n);
        return r;
    endfunction

    task automatic send_word(input logic [31:0] pw, input logic [7:0] fx,
                             input logic [7:0] fy, input logic [7:0] fz);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        packed_word <= pw;
        format_x    <= fx;
        format_y    <= fy;
        format_z    <= fz;
        expected_quats.push_back(decode_quat(pw, fx, fy, fz));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        word_count++;
    endtask

    task automatic hold_off;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_quats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_format;
        int k;
        logic [7:0] f;
        k = $urandom_range(1, 7);
        f = 8'hFF << (8 - k);
        f = f | (8'($urandom) & (8'hFF >> (k + 1)));
        return f;
    endfunction

    task automatic test_directed;
        send_word(32'h0000_0000, 8'h00, 8'h00, 8'h00);
        send_word(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(32'hFFFF_FFFF, 8'h80, 8'h80, 8'h80);
        send_word(32'h7FEF_FDFF, 8'h80, 8'h80, 8'h80);
        send_word(32'h0000_0000, 8'hFE, 8'hFE, 8'hFE);
        send_word(32'hFFFF_FFFF, 8'hFE, 8'hFE, 8'hFE);
        send_word(32'h7FEF_FDFF, 8'hFE, 8'hFD, 8'hFC);
        send_word(32'h7FEF_FDFF, 8'hBF, 8'hDF, 8'hEF);
        send_word(32'h8010_0200, 8'hC0, 8'hE0, 8'hF0);
        send_word(32'h1234_5678, 8'h7F, 8'hC5, 8'hF8);
        send_word(32'hA5A5_5A5A, 8'hF7, 8'h7F, 8'hFB);
        send_word(32'h5A5A_A5A5, 8'h9C, 8'hE3, 8'h01);
        send_word(32'hFFE0_0000, 8'h80, 8'h00, 8'hFF);
        send_word(32'h001F_FC00, 8'hFF, 8'hA0, 8'h00);
        send_word(32'h0000_03FF, 8'h00, 8'h00, 8'hBF);
        for (int k = 1; k <= 7; k++)
            send_word($urandom, 8'hFF << (8 - k), 8'hFF << (8 - k), 8'hFF << (8 - k));
    endtask

    task automatic test_random(input int n);
        logic [7:0] f[3];
        for (int i = 0; i < n; i++)
        begin
            for (int a = 0; a < 3; a++)
                f[a] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : random_format();
            send_word($urandom, f[0], f[1], f[2]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else if (idle_enable && stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left = 0;
        end
    end

    always @(posedge clk)
    begin
        quat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (expected_quats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %0d %0d %0d %0d",
                             quat_x, quat_y, quat_z, quat_w);
            end
            else
            begin
                e = expected_quats.pop_front();
                if (e.qx !== quat_x || e.qy !== quat_y || e.qz !== quat_z
                    || e.qw !== quat_w)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 e.qx, e.qy, e.qz, e.qw, quat_x, quat_y, quat_z, quat_w);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        packed_word    = '0;
        format_x       = '0;
        format_y       = '0;
        format_z       = '0;
        mismatch_count = 0;
        word_count     = 0;
        result_count   = 0;
        idle_enable    = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        hold_off();
        test_random(900);
        idle_enable = 1'b0;
        test_random(230);
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_quats.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (150) @(posedge clk);
        $display("Decoded %0d words, checked %0d quaternions, %0d mismatches.",
                 word_count, result_count, mismatch_count);
        if (mismatch_count == 0 && expected_quats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
